// File: sv/csts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_pkg : shared types and constants for the C source token scanner
// Beat layouts, token and diagnostic codes, and character class helpers.
// ----------------------------------------------------------------------------
package csts_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int LENGTH_BITS = 16;
	localparam int LINE_BITS   = 24;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       end_of_input;
	} csts_in_t;

	typedef struct packed {
		logic [5:0]             token_type;
		logic [OFFSET_BITS-1:0] start_offset;
		logic [LENGTH_BITS-1:0] token_length;
		logic [LINE_BITS-1:0]   line_number;
		logic [3:0]             diag_code;
		logic                   last;
	} csts_out_t;

	// token kinds
	localparam logic [5:0] T_IDENT    = 6'd0;
	localparam logic [5:0] T_PPNUM    = 6'd1;
	localparam logic [5:0] T_CHAR     = 6'd2;
	localparam logic [5:0] T_STRING   = 6'd3;
	localparam logic [5:0] T_LBRACK   = 6'd4;
	localparam logic [5:0] T_RBRACK   = 6'd5;
	localparam logic [5:0] T_LPAREN   = 6'd6;
	localparam logic [5:0] T_RPAREN   = 6'd7;
	localparam logic [5:0] T_LBRACE   = 6'd8;
	localparam logic [5:0] T_RBRACE   = 6'd9;
	localparam logic [5:0] T_PERIOD   = 6'd10;
	localparam logic [5:0] T_ELLIPSIS = 6'd11;
	localparam logic [5:0] T_ARROW    = 6'd12;
	localparam logic [5:0] T_INC      = 6'd13;
	localparam logic [5:0] T_DEC      = 6'd14;
	localparam logic [5:0] T_AMP      = 6'd15;
	localparam logic [5:0] T_STAR     = 6'd16;
	localparam logic [5:0] T_PLUS     = 6'd17;
	localparam logic [5:0] T_MINUS    = 6'd18;
	localparam logic [5:0] T_TILDE    = 6'd19;
	localparam logic [5:0] T_BANG     = 6'd20;
	localparam logic [5:0] T_SLASH    = 6'd21;
	localparam logic [5:0] T_PCT      = 6'd22;
	localparam logic [5:0] T_LL       = 6'd23;
	localparam logic [5:0] T_GG       = 6'd24;
	localparam logic [5:0] T_LT       = 6'd25;
	localparam logic [5:0] T_GT       = 6'd26;
	localparam logic [5:0] T_LE       = 6'd27;
	localparam logic [5:0] T_GE       = 6'd28;
	localparam logic [5:0] T_EQEQ     = 6'd29;
	localparam logic [5:0] T_NE       = 6'd30;
	localparam logic [5:0] T_CARET    = 6'd31;
	localparam logic [5:0] T_PIPE     = 6'd32;
	localparam logic [5:0] T_ANDAND   = 6'd33;
	localparam logic [5:0] T_OROR     = 6'd34;
	localparam logic [5:0] T_QUEST    = 6'd35;
	localparam logic [5:0] T_COLON    = 6'd36;
	localparam logic [5:0] T_SEMI     = 6'd37;
	localparam logic [5:0] T_ASSIGN   = 6'd38;
	localparam logic [5:0] T_MULEQ    = 6'd39;
	localparam logic [5:0] T_DIVEQ    = 6'd40;
	localparam logic [5:0] T_MODEQ    = 6'd41;
	localparam logic [5:0] T_ADDEQ    = 6'd42;
	localparam logic [5:0] T_SUBEQ    = 6'd43;
	localparam logic [5:0] T_LLE      = 6'd44;
	localparam logic [5:0] T_GGE      = 6'd45;
	localparam logic [5:0] T_ANDEQ    = 6'd46;
	localparam logic [5:0] T_XOREQ    = 6'd47;
	localparam logic [5:0] T_OREQ     = 6'd48;
	localparam logic [5:0] T_COMMA    = 6'd49;
	localparam logic [5:0] T_HASH     = 6'd50;
	localparam logic [5:0] T_HASHHASH = 6'd51;
	localparam logic [5:0] T_UNKNOWN  = 6'd52;
	localparam logic [5:0] T_EOF      = 6'd53;

	// diagnostics
	localparam logic [3:0] D_NONE        = 4'd0;
	localparam logic [3:0] D_NUL         = 4'd1;
	localparam logic [3:0] D_EMPTY_CHAR  = 4'd2;
	localparam logic [3:0] D_BAD_HEX     = 4'd3;
	localparam logic [3:0] D_BAD_ESC     = 4'd4;
	localparam logic [3:0] D_UNTERM_CHR  = 4'd5;
	localparam logic [3:0] D_UNTERM_STR  = 4'd6;
	localparam logic [3:0] D_UNTERM_CMT  = 4'd7;
	localparam logic [3:0] D_WIDE_CHAR   = 4'd8;
	localparam logic [3:0] D_WIDE_STRING = 4'd9;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return c >= "0" && c <= "7";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_identch(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_simple_esc(input logic [7:0] c);
		return c == "'" || c == "\"" || c == "?" || c == "\\" || c == "a" || c == "b" ||
			c == "f" || c == "n" || c == "r" || c == "t" || c == "v";
	endfunction

	function automatic logic needs_la(input logic [7:0] c);
		return c == "-" || c == "+" || c == "&" || c == "*" || c == "!" || c == "/" ||
			c == "%" || c == "<" || c == ">" || c == "=" || c == "^" || c == "|" ||
			c == "#";
	endfunction

	// single-byte punctuator, UNKNOWN when the byte is none
	function automatic logic [5:0] single_type(input logic [7:0] c);
		logic [5:0] t;
		case (c)
			"[":     t = T_LBRACK;
			"]":     t = T_RBRACK;
			"(":     t = T_LPAREN;
			")":     t = T_RPAREN;
			"{":     t = T_LBRACE;
			"}":     t = T_RBRACE;
			"&":     t = T_AMP;
			"*":     t = T_STAR;
			"+":     t = T_PLUS;
			"-":     t = T_MINUS;
			"~":     t = T_TILDE;
			"!":     t = T_BANG;
			"/":     t = T_SLASH;
			"%":     t = T_PCT;
			"<":     t = T_LT;
			">":     t = T_GT;
			"^":     t = T_CARET;
			"|":     t = T_PIPE;
			"?":     t = T_QUEST;
			":":     t = T_COLON;
			";":     t = T_SEMI;
			"=":     t = T_ASSIGN;
			",":     t = T_COMMA;
			"#":     t = T_HASH;
			default: t = T_UNKNOWN;
		endcase
		return t;
	endfunction

	// two-byte punctuator; UNKNOWN when the pair forms none
	function automatic logic [5:0] pair_type(input logic [7:0] p, input logic [7:0] x);
		logic [5:0] t;
		t = T_UNKNOWN;
		if (x == "=") begin
			case (p)
				"-":     t = T_SUBEQ;
				"+":     t = T_ADDEQ;
				"&":     t = T_ANDEQ;
				"*":     t = T_MULEQ;
				"!":     t = T_NE;
				"/":     t = T_DIVEQ;
				"%":     t = T_MODEQ;
				"<":     t = T_LE;
				">":     t = T_GE;
				"=":     t = T_EQEQ;
				"^":     t = T_XOREQ;
				"|":     t = T_OREQ;
				default: t = T_UNKNOWN;
			endcase
		end else if (p == "-" && x == ">") begin
			t = T_ARROW;
		end else if (p == "-" && x == "-") begin
			t = T_DEC;
		end else if (p == "+" && x == "+") begin
			t = T_INC;
		end else if (p == "&" && x == "&") begin
			t = T_ANDAND;
		end else if (p == "|" && x == "|") begin
			t = T_OROR;
		end else if (p == "#" && x == "#") begin
			t = T_HASHHASH;
		end
		return t;
	endfunction

endpackage

// File: sv/c_source_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_token_scanner : C89 preprocessing token scanner
// Sorts a byte stream of C source into tokens with offset, length and line.
// ----------------------------------------------------------------------------
// Usage:
//   in_beat carries one source byte and an end flag; out_beat carries one
//   token. Both channels are valid/ready.
//   A byte is scanned in the cycle it is accepted; its tokens (none to three)
//   sit in a three-entry result buffer from the next cycle on, one per beat,
//   last set on the final token of that byte.
//   Throughput: one byte per cycle while each byte gives at most one token
//   and out_ready is high; a byte that gives more tokens holds the input
//   until the single output port is taking the last of its buffered tokens.
//   in_ready stays high while the last buffered token is being taken, so a
//   steady stream does not bubble. When out_ready is low the buffer holds and
//   input is refused once it is not empty.
//   The byte flagged as end of input closes any open token, reports an open
//   comment, emits EOF at the file length unless all three result slots are
//   full, and returns the scanner to its reset state (line 1, offset 0).
//   Reset empties the buffer and clears scanner state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module c_source_token_scanner
	import csts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  csts_in_t  in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output csts_out_t out_beat
);

	typedef enum logic [4:0] {
		M_IDLE, M_IDENT, M_LSEEN, M_NUM, M_NUMEXP, M_DOT1, M_DOT2, M_LIT_FIRST,
		M_LIT_BODY, M_LIT_ESC, M_LIT_OCT1, M_LIT_OCT2, M_LIT_HEX0, M_LIT_HEX,
		M_WIDE, M_CMT, M_CMT_STAR, M_PUNCT, M_PUNCT2
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [7:0]             q;
		logic [OFFSET_BITS-1:0] tstart;
		logic [LENGTH_BITS-1:0] len;
		logic [LINE_BITS-1:0]   line;
	} scan_t;

	typedef struct packed {
		scan_t                  s;
		logic                   emit;
		logic [5:0]             ty;
		logic [3:0]             dg;
		logic                   again;
		logic                   ovr;
		logic [OFFSET_BITS-1:0] ostart;
	} step_t;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

	function automatic scan_t go_idle(input scan_t s);
		scan_t r;
		r = s;
		r.mode = M_IDLE;
		r.q = CH_NUL;
		return r;
	endfunction

	function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] l);
		return (l != LEN_MAX) ? l + 1'b1 : l;
	endfunction

	// one scanning decision; again means the byte must be looked at once more
	function automatic step_t scan_step(input scan_t s, input logic [7:0] c,
			input logic [OFFSET_BITS-1:0] pos, input logic virt);
		step_t r;
		r.s = s;
		r.emit = 1'b0;
		r.ty = T_UNKNOWN;
		r.dg = D_NONE;
		r.again = 1'b0;
		r.ovr = 1'b0;
		r.ostart = s.tstart;
		case (s.mode)
			M_IDLE: begin
				r.s.tstart = pos;
				if (virt) begin
					r.s.len = '0;
					r.emit = 1'b1;
					r.ty = T_EOF;
				end else begin
					r.s.len = LENGTH_BITS'(1);
					if (c == CH_NUL) begin
						r.emit = 1'b1;
						r.dg = D_NUL;
					end else if (c == " " || c == CH_CR || c == CH_TAB) begin
						r.s.mode = M_IDLE;
					end else if (c == CH_NL) begin
						if (s.line != LINE_MAX)
							r.s.line = s.line + 1'b1;
					end else if (c == "L") begin
						r.s.mode = M_LSEEN;
					end else if (is_alpha(c) || c == "_") begin
						r.s.mode = M_IDENT;
					end else if (is_digit(c)) begin
						r.s.mode = M_NUM;
					end else if (c == ".") begin
						r.s.mode = M_DOT1;
					end else if (c == "'" || c == "\"") begin
						r.s.q = c;
						r.s.mode = (c == "'") ? M_LIT_FIRST : M_LIT_BODY;
					end else if (needs_la(c)) begin
						r.s.q = c;
						r.s.mode = M_PUNCT;
					end else begin
						r.emit = 1'b1;
						r.ty = single_type(c);
					end
				end
			end
			M_IDENT: begin
				if (is_identch(c)) begin
					r.s.len = bump(s.len);
				end else begin
					r.emit = 1'b1; r.ty = T_IDENT; r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_LSEEN: begin
				if (c == "'" || c == "\"") begin
					r.s.len = bump(s.len); r.s.q = c; r.s.mode = M_WIDE;
				end else if (is_identch(c)) begin
					r.s.len = bump(s.len); r.s.mode = M_IDENT;
				end else begin
					r.emit = 1'b1; r.ty = T_IDENT; r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_NUM: begin
				if (c == "e" || c == "E") begin
					r.s.len = bump(s.len); r.s.mode = M_NUMEXP;
				end else if (is_identch(c) || c == ".") begin
					r.s.len = bump(s.len);
				end else begin
					r.emit = 1'b1; r.ty = T_PPNUM; r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_NUMEXP: begin
				r.s.mode = M_NUM;
				if (c == "+" || c == "-")
					r.s.len = bump(s.len);
				else
					r.again = 1'b1;
			end
			M_DOT1: begin
				if (c == ".") begin
					r.s.len = bump(s.len); r.s.mode = M_DOT2;
				end else if (is_digit(c)) begin
					r.s.len = bump(s.len); r.s.mode = M_NUM;
				end else begin
					r.emit = 1'b1; r.ty = T_PERIOD; r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_DOT2: begin
				if (c == ".") begin
					r.s = go_idle(s); r.s.len = bump(s.len);
					r.emit = 1'b1; r.ty = T_ELLIPSIS;
				end else begin
					// first period goes out, second one becomes a fresh DOT1
					r.s.len = LENGTH_BITS'(1);
					r.emit = 1'b1; r.ty = T_PERIOD;
					r.ovr = 1'b1; r.ostart = s.tstart;
					r.s.tstart = s.tstart + 1'b1;
					r.s.mode = M_DOT1; r.again = 1'b1;
				end
			end
			M_LIT_FIRST: begin
				if (c == "'") begin
					r.s = go_idle(s); r.s.len = bump(s.len);
					r.emit = 1'b1; r.dg = D_EMPTY_CHAR;
				end else begin
					r.s.mode = M_LIT_BODY; r.again = 1'b1;
				end
			end
			M_LIT_BODY: begin
				if (c == s.q) begin
					r.s = go_idle(s); r.s.len = bump(s.len);
					r.emit = 1'b1; r.ty = (s.q == "'") ? T_CHAR : T_STRING;
				end else if (c == "\\") begin
					r.s.len = bump(s.len); r.s.mode = M_LIT_ESC;
				end else if (c == CH_NL || c == CH_NUL) begin
					r.emit = 1'b1; r.dg = (s.q == "'") ? D_UNTERM_CHR : D_UNTERM_STR;
					r.s = go_idle(s); r.again = 1'b1;
				end else begin
					r.s.len = bump(s.len);
				end
			end
			M_LIT_ESC: begin
				if (is_octal(c)) begin
					r.s.len = bump(s.len); r.s.mode = M_LIT_OCT1;
				end else if (c == "x") begin
					r.s.len = bump(s.len); r.s.mode = M_LIT_HEX0;
				end else if (is_simple_esc(c)) begin
					r.s.len = bump(s.len); r.s.mode = M_LIT_BODY;
				end else begin
					r.emit = 1'b1; r.dg = D_BAD_ESC; r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_LIT_OCT1: begin
				if (is_octal(c)) begin
					r.s.len = bump(s.len); r.s.mode = M_LIT_OCT2;
				end else begin
					r.s.mode = M_LIT_BODY; r.again = 1'b1;
				end
			end
			M_LIT_OCT2: begin
				r.s.mode = M_LIT_BODY;
				if (is_octal(c))
					r.s.len = bump(s.len);
				else
					r.again = 1'b1;
			end
			M_LIT_HEX0: begin
				if (is_hex(c)) begin
					r.s.len = bump(s.len); r.s.mode = M_LIT_HEX;
				end else begin
					r.emit = 1'b1; r.dg = D_BAD_HEX; r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_LIT_HEX: begin
				if (is_hex(c)) begin
					r.s.len = bump(s.len);
				end else begin
					r.s.mode = M_LIT_BODY; r.again = 1'b1;
				end
			end
			M_WIDE: begin
				if (c == s.q) begin
					r.s = go_idle(s); r.s.len = bump(s.len);
					r.emit = 1'b1; r.dg = (s.q == "'") ? D_WIDE_CHAR : D_WIDE_STRING;
				end else if (c == CH_NL || c == CH_NUL) begin
					r.emit = 1'b1; r.dg = (s.q == "'") ? D_WIDE_CHAR : D_WIDE_STRING;
					r.s = go_idle(s); r.again = 1'b1;
				end else begin
					r.s.len = bump(s.len);
				end
			end
			M_CMT: begin
				r.s.len = bump(s.len);
				if (c == "*")
					r.s.mode = M_CMT_STAR;
				else if (c == CH_NL && s.line != LINE_MAX)
					r.s.line = s.line + 1'b1;
			end
			M_CMT_STAR: begin
				if (c == "/") begin
					r.s = go_idle(s);
				end else begin
					r.s.mode = M_CMT; r.again = 1'b1;
				end
			end
			M_PUNCT: begin
				if (s.q == "/" && c == "*") begin
					r.s.len = bump(s.len); r.s.q = CH_NUL; r.s.mode = M_CMT;
				end else if ((s.q == "<" || s.q == ">") && c == s.q) begin
					r.s.len = bump(s.len); r.s.mode = M_PUNCT2;
				end else if (pair_type(s.q, c) != T_UNKNOWN) begin
					r.s = go_idle(s); r.s.len = bump(s.len);
					r.emit = 1'b1; r.ty = pair_type(s.q, c);
				end else begin
					r.emit = 1'b1; r.ty = single_type(s.q);
					r.s = go_idle(s); r.again = 1'b1;
				end
			end
			M_PUNCT2: begin
				r.emit = 1'b1;
				if (c == "=") begin
					r.s = go_idle(s); r.s.len = bump(s.len);
					r.ty = (s.q == "<") ? T_LLE : T_GGE;
				end else begin
					r.ty = (s.q == "<") ? T_LL : T_GG;
					r.s = go_idle(s); r.again = 1'b1;
				end
			end
			default: begin
				r.s = go_idle(s); r.again = 1'b1;
			end
		endcase
		if (!r.ovr)
			r.ostart = r.s.tstart;
		return r;
	endfunction

	scan_t                  scan_q;
	logic [OFFSET_BITS-1:0] pos_q;
	csts_out_t              res_q [3];
	logic [1:0]             cnt_q;

	csts_out_t              slot [3];
	logic [1:0]             n_res;
	scan_t                  scan_nx;
	logic [OFFSET_BITS-1:0] pos_nx;
	logic                   accept;
	logic                   take;

	assign out_valid = cnt_q != 2'd0;
	assign out_beat  = res_q[0];
	assign take      = out_valid && out_ready;
	assign in_ready  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);
	assign accept    = in_valid && in_ready;

	always_comb begin
		scan_t                  cur;
		step_t                  r;
		logic                   act;
		logic [OFFSET_BITS-1:0] nxt;
		cur = scan_q;
		n_res = 2'd0;
		act = 1'b1;
		nxt = pos_q + 1'b1;
		for (int k = 0; k < 3; k++)
			slot[k] = '0;
		// real byte: at most three decisions chain on one byte
		for (int i = 0; i < 4; i++) begin
			if (act) begin
				r = scan_step(cur, in_beat.byte_req, pos_q, 1'b0);
				cur = r.s;
				act = r.again;
				if (r.emit && n_res != 2'd3) begin
					slot[n_res] = '{r.ty, r.ostart, r.s.len, r.s.line, r.dg, 1'b0};
					n_res = n_res + 1'b1;
				end
			end
		end
		if (in_beat.end_of_input) begin
			if (cur.mode == M_CMT || cur.mode == M_CMT_STAR) begin
				if (n_res != 2'd3) begin
					slot[n_res] = '{T_UNKNOWN, cur.tstart, cur.len, cur.line, D_UNTERM_CMT,
						1'b0};
					n_res = n_res + 1'b1;
				end
				cur = go_idle(cur);
			end
			act = 1'b1;
			// closing NUL, ends in EOF
			for (int i = 0; i < 4; i++) begin
				if (act) begin
					r = scan_step(cur, CH_NUL, nxt, 1'b1);
					cur = r.s;
					act = r.again;
					if (r.emit && n_res != 2'd3) begin
						slot[n_res] = '{r.ty, r.ostart, r.s.len, r.s.line, r.dg, 1'b0};
						n_res = n_res + 1'b1;
					end
				end
			end
			scan_nx = '{M_IDLE, CH_NUL, '0, '0, LINE_BITS'(1)};
			pos_nx = '0;
		end else begin
			scan_nx = cur;
			pos_nx = nxt;
		end
		for (int k = 0; k < 3; k++)
			slot[k].last = (2'(k + 1) == n_res);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '{M_IDLE, CH_NUL, '0, '0, LINE_BITS'(1)};
			pos_q <= '0;
			cnt_q <= 2'd0;
		end else begin
			if (take) begin
				res_q[0] <= res_q[1];
				res_q[1] <= res_q[2];
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept) begin
				scan_q <= scan_nx;
				pos_q <= pos_nx;
				res_q <= slot;
				cnt_q <= n_res;
			end
		end
	end

`ifndef SYNTH
	// end of input always produces at least one beat
	a_end_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_beat.end_of_input |=> out_valid)
		else $error("no result after end of input");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.token_type == T_EOF |-> out_beat.last)
		else $error("EOF not marked last");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_beat.line_number != '0)
		else $error("line number zero");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cnt_q != 2'd1 |-> !out_beat.last)
		else $error("last set before final beat of a byte");
`endif

endmodule

// File: dv/tb_c_source_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_source_token_scanner : self-checking bench for the C source scanner
// Streams C source fragments and noise bytes through the scanner, predicts
// the token beats of every accepted byte and checks them in order, with
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_c_source_token_scanner;
	import csts_pkg::*;

	typedef enum int {
		M_IDLE, M_IDENT, M_LSEEN, M_NUM, M_NUMEXP, M_DOT1, M_DOT2, M_LFIRST, M_LBODY,
		M_LESC, M_LOCT1, M_LOCT2, M_LHEX0, M_LHEX, M_WIDE, M_CMT, M_CMTSTAR, M_PUNCT,
		M_PUNCT2
	} scan_mode_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	csts_in_t  in_beat;
	logic      out_valid;
	logic      out_ready;
	csts_out_t out_beat;

	c_source_token_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat (out_beat)
	);

	// scanner shadow state
	scan_mode_t             mode;
	logic [7:0]             quote;
	logic [OFFSET_BITS-1:0] tok_start;
	logic [OFFSET_BITS-1:0] byte_pos;
	logic [LINE_BITS-1:0]   line_cnt;
	logic [LENGTH_BITS-1:0] tok_len;
	csts_out_t              byte_tokens[3];
	int                     n_tokens;

	csts_out_t expected_tokens[$];
	int        errors;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        recv_hold;
	int        quiet_cycles;

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = 1'b1;
			#6 clk = 1'b0;
		end
	end

	function automatic bit alpha_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit word_ch(logic [7:0] c);
		return alpha_ch(c) || digit_ch(c) || c == "_";
	endfunction

	function automatic bit hexdig_ch(logic [7:0] c);
		return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [5:0] one_char_punct(logic [7:0] c);
		case (c)
			"[": return T_LBRACK;  "]": return T_RBRACK;  "(": return T_LPAREN;
			")": return T_RPAREN;  "{": return T_LBRACE;  "}": return T_RBRACE;
			"&": return T_AMP;     "*": return T_STAR;    "+": return T_PLUS;
			"-": return T_MINUS;   "~": return T_TILDE;   "!": return T_BANG;
			"/": return T_SLASH;   "%": return T_PCT;     "<": return T_LT;
			">": return T_GT;      "^": return T_CARET;   "|": return T_PIPE;
			"?": return T_QUEST;   ":": return T_COLON;   ";": return T_SEMI;
			"=": return T_ASSIGN;  ",": return T_COMMA;   "#": return T_HASH;
			default: return T_UNKNOWN;
		endcase
	endfunction

	function automatic bit may_extend(logic [7:0] c);
		return c == "-" || c == "+" || c == "&" || c == "*" || c == "!" || c == "/" ||
			c == "%" || c == "<" || c == ">" || c == "=" || c == "^" || c == "|" ||
			c == "#";
	endfunction

	// two-byte punctuator, T_UNKNOWN when the pair forms none
	function automatic logic [5:0] two_char_punct(logic [7:0] p, logic [7:0] x);
		if (x == "=") begin
			case (p)
				"-": return T_SUBEQ;  "+": return T_ADDEQ;  "&": return T_ANDEQ;
				"*": return T_MULEQ;  "!": return T_NE;     "/": return T_DIVEQ;
				"%": return T_MODEQ;  "<": return T_LE;     ">": return T_GE;
				"=": return T_EQEQ;   "^": return T_XOREQ;  "|": return T_OREQ;
				default: return T_UNKNOWN;
			endcase
		end
		if (p == "-" && x == ">") return T_ARROW;
		if (p == "-" && x == "-") return T_DEC;
		if (p == "+" && x == "+") return T_INC;
		if (p == "&" && x == "&") return T_ANDAND;
		if (p == "|" && x == "|") return T_OROR;
		if (p == "#" && x == "#") return T_HASHHASH;
		return T_UNKNOWN;
	endfunction

	task automatic add_token(logic [5:0] kind, logic [3:0] diag);
		if (n_tokens < 3) begin
			byte_tokens[n_tokens] = '{kind, tok_start, tok_len, line_cnt, diag, 1'b0};
			n_tokens++;
		end
	endtask

	task automatic grow_len();
		if (tok_len != '1) tok_len++;
	endtask

	task automatic scanner_clear();
		mode      = M_IDLE;
		quote     = 8'd0;
		tok_start = '0;
		byte_pos  = '0;
		line_cnt  = LINE_BITS'(1);
		tok_len   = '0;
	endtask

	task automatic close_tok(logic [5:0] kind, logic [3:0] diag);
		add_token(kind, diag);
		mode  = M_IDLE;
		quote = 8'd0;
	endtask

	// one byte through the scanner; a byte that ends a token is rescanned
	task automatic scan_char(logic [7:0] c, logic [OFFSET_BITS-1:0] at, bit eof_pass);
		bit         again;
		logic [5:0] t;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (mode)
				M_IDLE: begin
					tok_start = at;
					if (eof_pass) begin
						tok_len = '0;
						add_token(T_EOF, D_NONE);
					end else begin
						tok_len = LENGTH_BITS'(1);
						if (c == CH_NUL) add_token(T_UNKNOWN, D_NUL);
						else if (c == " " || c == CH_CR || c == CH_TAB) ;
						else if (c == CH_NL) begin
							if (line_cnt != '1) line_cnt++;
						end else if (c == "L") mode = M_LSEEN;
						else if (alpha_ch(c) || c == "_") mode = M_IDENT;
						else if (digit_ch(c)) mode = M_NUM;
						else if (c == ".") mode = M_DOT1;
						else if (c == "'" || c == "\"") begin
							quote = c;
							mode  = (c == "'") ? M_LFIRST : M_LBODY;
						end else if (may_extend(c)) begin
							quote = c;
							mode  = M_PUNCT;
						end else add_token(one_char_punct(c), D_NONE);
					end
				end
				M_IDENT: begin
					if (word_ch(c)) grow_len();
					else begin close_tok(T_IDENT, D_NONE); again = 1'b1; end
				end
				M_LSEEN: begin
					if (c == "'" || c == "\"") begin
						grow_len(); quote = c; mode = M_WIDE;
					end else if (word_ch(c)) begin
						grow_len(); mode = M_IDENT;
					end else begin close_tok(T_IDENT, D_NONE); again = 1'b1; end
				end
				M_NUM: begin
					if (c == "e" || c == "E") begin grow_len(); mode = M_NUMEXP; end
					else if (word_ch(c) || c == ".") grow_len();
					else begin close_tok(T_PPNUM, D_NONE); again = 1'b1; end
				end
				M_NUMEXP: begin
					mode = M_NUM;
					if (c == "+" || c == "-") grow_len();
					else again = 1'b1;
				end
				M_DOT1: begin
					if (c == ".") begin grow_len(); mode = M_DOT2; end
					else if (digit_ch(c)) begin grow_len(); mode = M_NUM; end
					else begin close_tok(T_PERIOD, D_NONE); again = 1'b1; end
				end
				M_DOT2: begin
					if (c == ".") begin
						grow_len(); close_tok(T_ELLIPSIS, D_NONE);
					end else begin
						// ".." splits: first period out, second one rescanned
						tok_len = LENGTH_BITS'(1);
						add_token(T_PERIOD, D_NONE);
						tok_start++;
						mode  = M_DOT1;
						again = 1'b1;
					end
				end
				M_LFIRST: begin
					if (c == "'") begin grow_len(); close_tok(T_UNKNOWN, D_EMPTY_CHAR); end
					else begin mode = M_LBODY; again = 1'b1; end
				end
				M_LBODY: begin
					if (c == quote) begin
						grow_len();
						close_tok(quote == "'" ? T_CHAR : T_STRING, D_NONE);
					end else if (c == "\\") begin grow_len(); mode = M_LESC; end
					else if (c == CH_NL || c == CH_NUL) begin
						close_tok(T_UNKNOWN, quote == "'" ? D_UNTERM_CHR : D_UNTERM_STR);
						again = 1'b1;
					end else grow_len();
				end
				M_LESC: begin
					if (c >= "0" && c <= "7") begin grow_len(); mode = M_LOCT1; end
					else if (c == "x") begin grow_len(); mode = M_LHEX0; end
					else if (c == "'" || c == "\"" || c == "?" || c == "\\" || c == "a" ||
						c == "b" || c == "f" || c == "n" || c == "r" || c == "t" ||
						c == "v") begin
						grow_len(); mode = M_LBODY;
					end else begin close_tok(T_UNKNOWN, D_BAD_ESC); again = 1'b1; end
				end
				M_LOCT1, M_LOCT2: begin
					if (c >= "0" && c <= "7") begin
						grow_len();
						mode = (mode == M_LOCT1) ? M_LOCT2 : M_LBODY;
					end else begin mode = M_LBODY; again = 1'b1; end
				end
				M_LHEX0: begin
					if (hexdig_ch(c)) begin grow_len(); mode = M_LHEX; end
					else begin close_tok(T_UNKNOWN, D_BAD_HEX); again = 1'b1; end
				end
				M_LHEX: begin
					if (hexdig_ch(c)) grow_len();
					else begin mode = M_LBODY; again = 1'b1; end
				end
				M_WIDE: begin
					if (c == quote) begin
						grow_len();
						close_tok(T_UNKNOWN, quote == "'" ? D_WIDE_CHAR : D_WIDE_STRING);
					end else if (c == CH_NL || c == CH_NUL) begin
						close_tok(T_UNKNOWN, quote == "'" ? D_WIDE_CHAR : D_WIDE_STRING);
						again = 1'b1;
					end else grow_len();
				end
				M_CMT: begin
					grow_len();
					if (c == "*") mode = M_CMTSTAR;
					else if (c == CH_NL && line_cnt != '1) line_cnt++;
				end
				M_CMTSTAR: begin
					if (c == "/") mode = M_IDLE;
					else begin mode = M_CMT; again = 1'b1; end
				end
				M_PUNCT: begin
					t = two_char_punct(quote, c);
					if (quote == "/" && c == "*") begin
						grow_len(); quote = 8'd0; mode = M_CMT;
					end else if ((quote == "<" || quote == ">") && c == quote) begin
						grow_len(); mode = M_PUNCT2;
					end else if (t != T_UNKNOWN) begin
						grow_len(); close_tok(t, D_NONE);
					end else begin
						close_tok(one_char_punct(quote), D_NONE); again = 1'b1;
					end
				end
				M_PUNCT2: begin
					if (c == "=") begin
						grow_len(); close_tok(quote == "<" ? T_LLE : T_GGE, D_NONE);
					end else begin
						close_tok(quote == "<" ? T_LL : T_GG, D_NONE); again = 1'b1;
					end
				end
				default: close_tok(T_UNKNOWN, D_NONE);
			endcase
		end
	endtask

	// tokens caused by one accepted byte, appended to the expected list
	task automatic predict_tokens(csts_in_t b);
		n_tokens = 0;
		scan_char(b.byte_req, byte_pos, 1'b0);
		if (b.end_of_input) begin
			if (mode == M_CMT || mode == M_CMTSTAR) close_tok(T_UNKNOWN, D_UNTERM_CMT);
			scan_char(CH_NUL, byte_pos + 1'b1, 1'b1);
			scanner_clear();
		end else begin
			byte_pos++;
		end
		if (n_tokens > 0) byte_tokens[n_tokens-1].last = 1'b1;
		for (int i = 0; i < n_tokens; i++) expected_tokens.push_back(byte_tokens[i]);
	endtask

	task automatic send_byte(logic [7:0] c, bit eoi);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		in_beat  = '{c, eoi};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_tokens(in_beat);
		@(negedge clk);
	endtask

	task automatic send_text(string s, bit eoi_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eoi_at_end && i == s.len() - 1);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
	endtask

	task automatic test_punctuators();
		send_text("x_1 L=Lq 0x1Fe+3 1E-9 .5e2 ... .. ->a++ --b <<= >>= << >> <= >= ",
			1'b0);
		send_text("== != &= ^= |= *= /= %= += -= && || ## # ? : ; , [](){}~^|&*+-!/%<>=",
			1'b0);
		send_text("@$` ..x\n", 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0B, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_text("ab", 1'b0);
		send_byte(CH_NUL, 1'b1);
	endtask

	task automatic test_literals();
		send_text("'a' '\\x4g' '\\q' '' \"s\\n\\101\\1234\\x41fz\\'\" 'b\n\"u", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_text("L'ab' L\"w\\\"\" L'x\n/* c\n*** */z/**/", 1'b0);
		send_text("'\\7", 1'b1);
	endtask

	task automatic test_end_of_input();
		send_text("/* open *", 1'b1);
		send_text("..a", 1'b1);
		send_text("  ", 1'b1);
		send_text("<<", 1'b1);
	endtask

	// mostly well-formed fragments with random content, some noise bytes
	task automatic test_random_source(int n_bytes);
		string frags[14];
		string s;
		int    sent;
		int    k;
		frags = '{"ident", "_v9", "L", "12.3e", "0xFF", ".", "'\\", "\"", "/*", "*/",
			"<", ">", "\n", " "};
		sent = 0;
		while (sent < n_bytes) begin
			k = $urandom_range(19);
			if (k < 14) s = frags[k];
			else if (k < 17) begin
				s = "";
				for (int i = 0; i < $urandom_range(4, 1); i++)
					s = {s, string'(byte'($urandom_range(126, 32)))};
			end else s = "";
			if (s.len() == 0) begin
				send_byte(8'($urandom_range(255)), $urandom_range(49) == 0);
				sent++;
			end else begin
				send_text(s, $urandom_range(29) == 0);
				sent += s.len();
			end
		end
		send_byte(";", 1'b1);
	endtask

	// receiver
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token beat type=%0d", out_beat.token_type);
				errors++;
			end else begin
				csts_out_t e;
				e = expected_tokens.pop_front();
				if (out_beat.token_type !== e.token_type) begin
					$error("token_type exp %0d got %0d", e.token_type, out_beat.token_type);
					errors++;
				end
				if (out_beat.start_offset !== e.start_offset) begin
					$error("start_offset exp %0d got %0d", e.start_offset,
						out_beat.start_offset);
					errors++;
				end
				if (out_beat.token_length !== e.token_length) begin
					$error("token_length exp %0d got %0d", e.token_length,
						out_beat.token_length);
					errors++;
				end
				if (out_beat.line_number !== e.line_number) begin
					$error("line_number exp %0d got %0d", e.line_number,
						out_beat.line_number);
					errors++;
				end
				if (out_beat.diag_code !== e.diag_code) begin
					$error("diag_code exp %0d got %0d", e.diag_code, out_beat.diag_code);
					errors++;
				end
				if (out_beat.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_beat.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL c_source_token_scanner");
			$finish;
		end
	end

	initial begin
		errors        = 0;
		quiet_cycles  = 0;
		recv_hold     = 0;
		send_idle_pct = 7;
		recv_idle_pct = 80;
		out_ready     = 1'b0;
		in_valid      = 1'b0;
		in_beat       = '0;
		arst_n        = 1'b0;
		scanner_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_punctuators();
		test_literals();
		test_end_of_input();
		test_random_source(18);
		drain();

		send_idle_pct = 80;
		recv_idle_pct = 7;
		test_random_source(18);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		recv_hold = 300;
		test_random_source(20);
		drain();

		repeat (10) @(posedge clk);
		if (errors == 0) $display("PASS c_source_token_scanner");
		else $display("FAIL c_source_token_scanner");
		$finish;
	end

endmodule

// File: c_source_token_scanner.f
sv/csts_pkg.sv
sv/c_source_token_scanner.sv
dv/tb_c_source_token_scanner.sv
